// ===== hdl/assert_macros.svh =====
// Assertion macros for the filter's RTL files; cssf_history uses them.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define CSSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define CSSF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CSSF_ASSERT(lbl, prop, msg)
`define CSSF_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/cssf_pkg.sv =====
// Package of the CRC-32 seen-set filter: sizes, constants, payload and control types,
// and the byte-wise CRC-32 step. No dependencies.
package cssf_pkg;

	localparam int HISTORY_DEPTH = 1024;
	localparam int HIST_AW = $clog2(HISTORY_DEPTH);
	localparam int HIST_CW = $clog2(HISTORY_DEPTH + 1);

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] signature;
		logic        already_seen;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [31:0] sig;
	} hist_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic        seen;
		logic [31:0] sig;
	} hist_stat_t;

	typedef enum logic [1:0] {
		HS_IDLE,
		HS_SCAN,
		HS_DONE
	} hist_state_t;

	// Reflected CRC-32 over one byte, one polynomial step per bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/crc32_seen_set_filter.sv =====
// Top level of the CRC-32 seen-set filter: request handshake, output register.
// Depends on cssf_pkg, cssf_crc_unit and cssf_history.
//
//  channel | signals                           | payload
//  --------+-----------------------------------+-------------------------------
//  item    | item_valid, item_stall (out)      | item_t: data_byte, last_byte
//  result  | result_valid, result_stall (in)   | result_t: signature, already_seen
//
// A byte without the last mark produces no result.
// A last byte starts a scan of the N filled ring entries (up to HISTORY_DEPTH) before
// its result loads; a hit ends the scan sooner.
// The scan reads one entry per cycle through the single read port and one comparator.
// item_stall is high while a scan runs or its result waits for the output register.
// Reset clears the CRC to all ones, the ring pointer and wrap flag; ring contents
// are never read before being written, so no clearing pass is needed.
module crc32_seen_set_filter import cssf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic       item_acc;
	logic [31:0] signature;
	hist_req_t  hreq;
	hist_stat_t hstat;
	logic       res_take;
	logic       result_valid_q;
	result_t    result_q;

	// Hold off new requests while the history is scanning or holding a result.
	assign item_stall = hstat.busy;
	assign item_acc   = item_valid && !item_stall;

	cssf_crc_unit u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (item_acc),
		.data_byte (item.data_byte),
		.last_byte (item.last_byte),
		.signature (signature)
	);

	// Launch the ring search on the last byte of a string.
	assign hreq.start = item_acc && item.last_byte;
	assign hreq.sig   = signature;

	cssf_history u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (hreq),
		.res_take (res_take),
		.stat     (hstat)
	);

	// Move the finished result out when the output register is free or draining.
	assign res_take = hstat.done && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Payload only changes on load, so a stalled result holds.
	always_ff @(posedge clk) begin
		if (res_take) begin
			result_q.signature    <= hstat.sig;
			result_q.already_seen <= hstat.seen;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hdl/cssf_crc_unit.sv =====
// Running CRC-32 register with its byte update.
// Depends on cssf_pkg.
module cssf_crc_unit import cssf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic [31:0] signature
);

	logic [31:0] crc_q;
	logic [31:0] crc_next;

	assign crc_next  = crc_byte(crc_q, data_byte);
	assign signature = ~crc_next;

	// Restart from all ones after the last byte of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_ALL_ONES;
		end else if (advance) begin
			crc_q <= last_byte ? CRC_ALL_ONES : crc_next;
		end
	end

endmodule

// ===== hdl/cssf_history.sv =====
// Signature history ring: memory, scan sequencer with one shared compare, and recording.
// Depends on cssf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cssf_history import cssf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hist_req_t  req,
	input  logic       res_take,
	output hist_stat_t stat
);

	logic [31:0] mem [HISTORY_DEPTH];

	hist_state_t state_q, state_d;
	logic [31:0] sig_q;
	logic [HIST_CW-1:0] idx_q;
	logic [HIST_AW-1:0] wptr_q;
	logic wrapped_q;
	logic seen_q;
	logic [31:0] rd_data_s1;
	logic rd_vld_s1;

	logic [HIST_CW-1:0] count;
	logic issue, hit, miss;

	assign count = wrapped_q ? HIST_CW'(HISTORY_DEPTH) : HIST_CW'(wptr_q);
	assign issue = (state_q == HS_SCAN) && (idx_q != count);
	assign hit   = (state_q == HS_SCAN) && rd_vld_s1 && (rd_data_s1 == sig_q);
	assign miss  = (state_q == HS_SCAN) && !rd_vld_s1 && (idx_q == count) && !hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			HS_IDLE: begin
				if (req.start) state_d = HS_SCAN;
			end
			HS_SCAN: begin
				if (hit || miss) state_d = HS_DONE;
			end
			HS_DONE: begin
				if (res_take) state_d = HS_IDLE;
			end
			default: state_d = HS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			wptr_q    <= '0;
			wrapped_q <= 1'b0;
			seen_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (req.start && state_q == HS_IDLE) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + HIST_CW'(1);
			end
			if (hit || miss) seen_q <= hit;
			if (miss) begin
				if (wptr_q == HIST_AW'(HISTORY_DEPTH - 1)) begin
					wptr_q    <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wptr_q <= wptr_q + HIST_AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && state_q == HS_IDLE) sig_q <= req.sig;
	end

	always_ff @(posedge clk) begin
		if (issue) rd_data_s1 <= mem[idx_q[HIST_AW-1:0]];
		if (miss)  mem[wptr_q] <= sig_q;
	end

	assign stat.busy = (state_q != HS_IDLE);
	assign stat.done = (state_q == HS_DONE);
	assign stat.seen = seen_q;
	assign stat.sig  = sig_q;

	`CSSF_NEVER(a_start_busy, req.start && state_q != HS_IDLE, "start while history busy")
	`CSSF_ASSERT(a_idx_bound, (state_q == HS_SCAN) |-> (idx_q <= count), "scan index past fill")
	`CSSF_NEVER(a_wrap_sticky, $fell(wrapped_q), "ring wrap flag cleared")
	`CSSF_ASSERT(a_ptr_hold, (state_q != HS_SCAN) |=> $stable(wptr_q), "pointer moved outside scan")

endmodule
